FILE: rtl/plc_pkg.sv
package plc_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 5;
	localparam int LEN_W  = 5;
	localparam int OP_W   = 3;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_REMOVE = 3'd1,
		OP_READ   = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_EMPTY  = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [POS_W-1:0] position;
		data_t            value;
	} cmd_item_t;

	typedef struct packed {
		logic             ok;
		data_t            read_value;
		logic [LEN_W-1:0] length;
	} rsp_item_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic  append_en;
		logic  remove_en;
		logic  clear_en;
		data_t value;
	} cell_ctl_t;

endpackage

FILE: rtl/plc_stream_if.sv
interface plc_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface

FILE: rtl/plc_cell.sv
module plc_cell #(
	parameter int IDX_W = 5,
	parameter int IDX   = 0
) (
	input  logic                clk,
	input  plc_pkg::cell_ctl_t  ctl,
	input  logic [IDX_W-1:0]    pos,
	input  logic [IDX_W-1:0]    cnt,
	input  plc_pkg::data_t      next_val,
	input  plc_pkg::data_t      rd_in,
	output plc_pkg::data_t      elem,
	output plc_pkg::data_t      rd_out
);

	localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

	plc_pkg::data_t elem_q;
	plc_pkg::data_t rd_q;

	always_ff @(posedge clk) begin
		if (ctl.clear_en) begin
			elem_q <= '0;
		end else if (ctl.append_en && (cnt == MyIdx)) begin
			elem_q <= ctl.value;
		end else if (ctl.remove_en && (MyIdx >= pos)) begin
			// close the gap: take the neighbour above
			elem_q <= next_val;
		end
	end

	// read chain: pick own element on a hit, else pass the one from below
	always_ff @(posedge clk) begin
		rd_q <= (pos == MyIdx) ? elem_q : rd_in;
	end

	assign elem   = elem_q;
	assign rd_out = rd_q;

endmodule

FILE: rtl/positional_list_store.sv
// Bounded ordered list of signed 32-bit values held in a row of LIST_DEPTH cells.
// cmd channel: one beat per command (opcode, position, value).
// rsp channel: exactly one beat per command (ok, read_value, length).
// Commands are taken one at a time: cmd.ready is high only while no command
// is in progress.
// Append, remove, clear, empty and failed reads are first captured in the command
// register; then any cell update is made in every cell at once (a remove shifts
// all cells above the position down) as the result register is loaded.
// A successful read instead lets the selected element walk up the read chain,
// one cell per cycle, to the last cell, and then loads the result register.
// A new command is taken only after the last one has loaded its result.
// The result sits in an output register, so rsp.valid holds with a stable beat
// while rsp.ready is low; a finished command waits there and the next command
// is accepted meanwhile, stalling only when it needs the busy result register.
// Reset clears the length, the state and the result valid flag. Cell contents are
// undefined until appended; no clearing pass is run.
module positional_list_store #(
	parameter int LIST_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	plc_stream_if.sink   cmd,
	plc_stream_if.source rsp
);

	localparam int CW  = $clog2(LIST_DEPTH + 1);
	localparam int W   = (CW > plc_pkg::POS_W) ? CW : plc_pkg::POS_W;
	localparam int RCW = $clog2(LIST_DEPTH);

	plc_pkg::state_t    state_q, state_d;
	plc_pkg::cmd_item_t cmd_q;
	plc_pkg::rsp_item_t rsp_q;
	logic               rsp_valid_q;
	logic [CW-1:0]      cnt_q, cnt_next;
	logic [RCW-1:0]     rd_cnt_q;

	logic               out_free, apply, load, rd_start;
	logic               append_ok, remove_ok, read_ok, op_ok;
	logic [W-1:0]       pos_w, cnt_w, depth_w, cnt_next_w;
	plc_pkg::cell_ctl_t ctl;
	plc_pkg::data_t     elem [LIST_DEPTH];
	plc_pkg::data_t     rd   [LIST_DEPTH];

	assign pos_w      = W'(cmd_q.position);
	assign cnt_w      = W'(cnt_q);
	assign depth_w    = W'(LIST_DEPTH);
	assign cnt_next_w = W'(cnt_next);

	assign append_ok = (pos_w == cnt_w) && (cnt_w < depth_w);
	assign remove_ok = pos_w < cnt_w;
	assign read_ok   = pos_w < cnt_w;

	always_comb begin
		op_ok    = 1'b0;
		cnt_next = cnt_q;
		unique case (cmd_q.opcode)
			plc_pkg::OP_APPEND: begin
				op_ok = append_ok;
				if (append_ok) cnt_next = cnt_q + 1'b1;
			end
			plc_pkg::OP_REMOVE: begin
				op_ok = remove_ok;
				if (remove_ok) cnt_next = cnt_q - 1'b1;
			end
			plc_pkg::OP_READ: begin
				op_ok = read_ok;
			end
			plc_pkg::OP_CLEAR: begin
				op_ok = 1'b1;
			end
			plc_pkg::OP_EMPTY: begin
				op_ok    = 1'b1;
				cnt_next = '0;
			end
			default: begin
				op_ok = 1'b0;
			end
		endcase
	end

	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		state_d   = state_q;
		apply     = 1'b0;
		load      = 1'b0;
		rd_start  = 1'b0;
		cmd.ready = 1'b0;
		unique case (state_q)
			plc_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) state_d = plc_pkg::ST_EXEC;
			end
			plc_pkg::ST_EXEC: begin
				if ((cmd_q.opcode == plc_pkg::OP_READ) && read_ok) begin
					rd_start = 1'b1;
					state_d  = plc_pkg::ST_READ;
				end else if (out_free) begin
					apply   = 1'b1;
					load    = 1'b1;
					state_d = plc_pkg::ST_IDLE;
				end
			end
			plc_pkg::ST_READ: begin
				if ((rd_cnt_q == '0) && out_free) begin
					load    = 1'b1;
					state_d = plc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = plc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= plc_pkg::ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			rd_cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (apply) cnt_q <= cnt_next;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			// wait for the hit to reach the top of the read chain
			if (rd_start) begin
				rd_cnt_q <= RCW'(LIST_DEPTH - 1);
			end else if ((state_q == plc_pkg::ST_READ) && (rd_cnt_q != '0)) begin
				rd_cnt_q <= rd_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) cmd_q <= cmd.payload;
		if (load) begin
			rsp_q.ok         <= op_ok;
			rsp_q.read_value <= (state_q == plc_pkg::ST_READ) ? rd[LIST_DEPTH-1] : '0;
			rsp_q.length     <= cnt_next_w[plc_pkg::LEN_W-1:0];
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	always_comb begin
		ctl.append_en = apply && (cmd_q.opcode == plc_pkg::OP_APPEND) && append_ok;
		ctl.remove_en = apply && (cmd_q.opcode == plc_pkg::OP_REMOVE) && remove_ok;
		ctl.clear_en  = apply && (cmd_q.opcode == plc_pkg::OP_CLEAR);
		ctl.value     = cmd_q.value;
	end

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		plc_pkg::data_t next_val, rd_in;

		if (i == LIST_DEPTH - 1) begin : g_top
			assign next_val = elem[i];
		end else begin : g_mid
			assign next_val = elem[i+1];
		end

		if (i == 0) begin : g_bot
			assign rd_in = '0;
		end else begin : g_up
			assign rd_in = rd[i-1];
		end

		plc_cell #(
			.IDX_W (W),
			.IDX   (i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.pos      (pos_w),
			.cnt      (cnt_w),
			.next_val (next_val),
			.rd_in    (rd_in),
			.elem     (elem[i]),
			.rd_out   (rd[i])
		);
	end

endmodule

FILE: rtl/plc_checker.sv
module plc_checker #(
	parameter int LIST_DEPTH = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cmd_valid,
	input logic                         cmd_ready,
	input logic [plc_pkg::OP_W-1:0]     cmd_opcode,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         rsp_ok,
	input plc_pkg::data_t               rsp_read_value,
	input logic [plc_pkg::LEN_W-1:0]    rsp_length
);

	localparam logic [plc_pkg::LEN_W-1:0] MaxLen = plc_pkg::LEN_W'(LIST_DEPTH);

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid
			&& $stable(rsp_ok) && $stable(rsp_read_value) && $stable(rsp_length))
		else $error("result beat changed while stalled");

	// one command in flight at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while another was in progress");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (LIST_DEPTH >= 32) || (rsp_length <= MaxLen))
		else $error("length beyond list depth");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> rsp_read_value == '0)
		else $error("failed command returned a value");

	// empty with a free result register answers with ok and length zero
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_opcode == plc_pkg::OP_EMPTY) && !rsp_valid
			|-> ##2 rsp_valid && rsp_ok && (rsp_length == '0))
		else $error("empty did not answer with length zero");

endmodule

bind positional_list_store plc_checker #(
	.LIST_DEPTH (LIST_DEPTH)
) u_plc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.cmd_opcode     (cmd.payload.opcode),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_ok         (rsp.payload.ok),
	.rsp_read_value (rsp.payload.read_value),
	.rsp_length     (rsp.payload.length)
);

FILE: tb/positional_list_store_tb.sv
module positional_list_store_tb;

	localparam int LIST_DEPTH  = 16;
	localparam int QUIET_LIMIT = 2000;

	typedef logic [plc_pkg::DATA_W-1:0] word_t;
	typedef logic [plc_pkg::POS_W-1:0]  pos_t;
	typedef logic [plc_pkg::OP_W-1:0]   op_t;

	logic clk;
	logic arst_n;

	plc_stream_if #(.payload_t(plc_pkg::cmd_item_t)) cmd_if ();
	plc_stream_if #(.payload_t(plc_pkg::rsp_item_t)) rsp_if ();

	positional_list_store #(.LIST_DEPTH(LIST_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	// shadow copy of the list
	plc_pkg::data_t            shadow_cells [LIST_DEPTH];
	logic [plc_pkg::LEN_W-1:0] shadow_len;

	plc_pkg::rsp_item_t pending_results [$];
	plc_pkg::rsp_item_t oldest;
	int                 mismatches;
	int                 quiet_cycles;
	int                 stall_left;
	bit                 steady;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic plc_pkg::rsp_item_t predict_list_result(plc_pkg::cmd_item_t c);
		plc_pkg::rsp_item_t r;
		r = '0;
		case (c.opcode)
			plc_pkg::OP_APPEND: begin
				if (c.position == shadow_len && shadow_len < LIST_DEPTH) begin
					shadow_cells[shadow_len] = c.value;
					shadow_len = shadow_len + 1'b1;
					r.ok = 1'b1;
				end
			end
			plc_pkg::OP_REMOVE: begin
				if (c.position < shadow_len) begin
					// close the gap left by the removed element
					for (int i = c.position; i + 1 < shadow_len; i++)
						shadow_cells[i] = shadow_cells[i + 1];
					shadow_len = shadow_len - 1'b1;
					r.ok = 1'b1;
				end
			end
			plc_pkg::OP_READ: begin
				if (c.position < shadow_len) begin
					r.read_value = shadow_cells[c.position];
					r.ok = 1'b1;
				end
			end
			plc_pkg::OP_CLEAR: begin
				for (int i = 0; i < LIST_DEPTH; i++)
					shadow_cells[i] = '0;
				r.ok = 1'b1;
			end
			plc_pkg::OP_EMPTY: begin
				shadow_len = '0;
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.length = shadow_len;
		return r;
	endfunction

	task automatic send_cmd(input op_t op, input pos_t pos, input plc_pkg::data_t val);
		plc_pkg::cmd_item_t c;
		int gap;
		c.opcode   = op;
		c.position = pos;
		c.value    = val;
		cmd_if.valid   <= 1'b1;
		cmd_if.payload <= c;
		do
			@(posedge clk);
		while (cmd_if.ready !== 1'b1);
		pending_results.push_back(predict_list_result(c));
		gap = steady ? 0 : pick_idle();
		// hold valid high when the next beat follows at once
		if (gap != 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random_cmd();
		int r;
		op_t            op;
		pos_t           pos;
		plc_pkg::data_t val;
		r = $urandom_range(0, 99);
		if (r < 38)
			op = plc_pkg::OP_APPEND;
		else if (r < 60)
			op = plc_pkg::OP_READ;
		else if (r < 80)
			op = plc_pkg::OP_REMOVE;
		else if (r < 86)
			op = plc_pkg::OP_CLEAR;
		else if (r < 92)
			op = plc_pkg::OP_EMPTY;
		else
			op = op_t'($urandom_range(5, 7));
		pos = pos_t'($urandom_range(0, 31));
		// mostly aim at valid positions so the list fills and shifts
		if (op == plc_pkg::OP_APPEND && $urandom_range(0, 4) != 0)
			pos = shadow_len;
		else if ((op == plc_pkg::OP_READ || op == plc_pkg::OP_REMOVE) && shadow_len != 0
				&& $urandom_range(0, 3) != 0)
			pos = pos_t'($urandom_range(0, shadow_len - 1));
		r = $urandom_range(0, 19);
		if (r == 0)
			val = 32'sh8000_0000;
		else if (r == 1)
			val = 32'sh7fff_ffff;
		else
			val = $urandom;
		send_cmd(op, pos, val);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_list();
		send_cmd(plc_pkg::OP_READ, 5'd0, 32'sd0);
		send_cmd(plc_pkg::OP_REMOVE, 5'd0, 32'sd0);
		send_cmd(plc_pkg::OP_APPEND, 5'd1, 32'sd7);
		send_cmd(3'd5, 5'd31, 32'sd0);
		send_cmd(plc_pkg::OP_EMPTY, 5'd0, 32'sd0);
	endtask

	task automatic test_fill_to_capacity();
		plc_pkg::data_t v;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			case (i)
				0: v = 32'sh8000_0000;
				1: v = 32'sh7fff_ffff;
				2: v = -32'sd1;
				3: v = 32'sd0;
				4: v = 32'shaaaa_aaaa;
				5: v = 32'sh5555_5555;
				default: v = $urandom;
			endcase
			send_cmd(plc_pkg::OP_APPEND, i[plc_pkg::POS_W-1:0], v);
		end
		send_cmd(plc_pkg::OP_APPEND, 5'd16, 32'sd1);
		send_cmd(plc_pkg::OP_READ, 5'd15, 32'sd0);
	endtask

	task automatic test_remove_and_shift();
		send_cmd(plc_pkg::OP_READ, 5'd16, 32'sd0);
		send_cmd(plc_pkg::OP_REMOVE, 5'd0, 32'sd0);
		send_cmd(plc_pkg::OP_REMOVE, 5'd14, 32'sd0);
		send_cmd(plc_pkg::OP_REMOVE, 5'd14, 32'sd0);
		send_cmd(plc_pkg::OP_READ, 5'd0, 32'sd0);
	endtask

	task automatic test_clear_and_empty();
		send_cmd(plc_pkg::OP_CLEAR, 5'd0, 32'sd0);
		send_cmd(plc_pkg::OP_READ, 5'd3, 32'sd0);
		send_cmd(plc_pkg::OP_EMPTY, 5'd0, 32'sd0);
		send_cmd(plc_pkg::OP_READ, 5'd0, 32'sd0);
		send_cmd(3'd7, 5'd0, 32'sd0);
	endtask

	task automatic test_random_traffic(input int n);
		for (int i = 0; i < n; i++)
			send_random_cmd();
	endtask

	task automatic test_drain_pause(input int n);
		cmd_if.valid <= 1'b0;
		@(posedge clk);
		wait_drained();
		test_random_traffic(n);
	endtask

	task automatic test_back_to_back(input int n);
		steady = 1'b1;
		test_random_traffic(n);
		steady = 1'b0;
	endtask

	// response side: random stalls unless steady
	always @(posedge clk) begin
		if (steady) begin
			rsp_if.ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left   <= stall_left - 1;
			rsp_if.ready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left   <= pick_idle();
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	task automatic report_field(input string name, input word_t want, input word_t got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat, expected none actual %0h", $time,
					rsp_if.payload);
			end else begin
				oldest = pending_results.pop_front();
				report_field("ok", word_t'(oldest.ok), word_t'(rsp_if.payload.ok));
				report_field("read_value", oldest.read_value, rsp_if.payload.read_value);
				report_field("length", word_t'(oldest.length),
					word_t'(rsp_if.payload.length));
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1)
				|| (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		cmd_if.valid   = 1'b0;
		cmd_if.payload = '0;
		rsp_if.ready   = 1'b0;
		shadow_len     = '0;
		mismatches     = 0;
		quiet_cycles   = 0;
		stall_left     = 0;
		steady         = 1'b0;
		for (int i = 0; i < LIST_DEPTH; i++)
			shadow_cells[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_fill_to_capacity();
		test_remove_and_shift();
		test_clear_and_empty();
		test_random_traffic(150);
		test_drain_pause(100);
		test_back_to_back(100);
		test_random_traffic(100);

		cmd_if.valid <= 1'b0;
		wait_drained();
		// allow a full read to ripple through before closing
		repeat (LIST_DEPTH + 6) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: positional_list_store.f
rtl/plc_pkg.sv
rtl/plc_stream_if.sv
rtl/plc_cell.sv
rtl/positional_list_store.sv
rtl/plc_checker.sv
tb/positional_list_store_tb.sv
